// File: hw/rtl/fpcs_pkg.sv
`default_nettype none

package fpcs_pkg;

	// sequencer phase codes
	localparam logic [1:0] PH_OFF    = 2'd0;
	localparam logic [1:0] PH_READY  = 2'd1;
	localparam logic [1:0] PH_CONFIG = 2'd2;
	localparam logic [1:0] PH_ACTIVE = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_WDT_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WDT_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOT_SEL    = 2'd2;

	// configuration reset values
	localparam logic       WDT_ENABLE_RST  = 1'b1;
	localparam logic [7:0] WDT_TIMEOUT_RST = 8'd3;
	localparam logic [1:0] BOOT_SEL_RST    = 2'd0;

	// item actions
	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam int unsigned TICK_W = 32;

	typedef struct packed {
		logic              action;
		logic              request_value;
		logic              rail_good;
		logic              fpga_kick;
		logic              fpga_mem_choice;
		logic [TICK_W-1:0] now_tick;
	} req_item_t;

	typedef struct packed {
		logic [1:0] phase;
		logic       power_enable;
		logic       mem_select_pin;
		logic [1:0] boot_pins;
		logic       run_request;
		logic       bus_accessible;
	} rsp_item_t;

	typedef struct packed {
		logic       wdt_enable;
		logic [7:0] wdt_timeout;
		logic [1:0] boot_sel;
	} cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/fpcs_in_reg.sv
`default_nettype none

module fpcs_in_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  fpcs_pkg::req_item_t  req,
	input  wire                  adv,
	output logic                 valid_s1,
	output fpcs_pkg::req_item_t  item_s1
);

	// stage holds its item until the step stage can move it on
	assign req_stall = valid_s1 & ~adv;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/fpcs_step.sv
`default_nettype none

module fpcs_step (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fire,
	input  fpcs_pkg::req_item_t  item,
	input  fpcs_pkg::cfg_t       cfg,
	output fpcs_pkg::rsp_item_t  result
);

	logic [1:0]                      phase_q,    phase_nx;
	logic                            run_q,      run_nx;
	logic                            next_mem_q, next_mem_nx;
	logic                            kick_q,     kick_nx;
	logic [fpcs_pkg::TICK_W-1:0]     stamp_q,    stamp_nx;
	logic                            power_q,    power_nx;
	logic                            mem_pin_q,  mem_pin_nx;
	logic [1:0]                      boot_q,     boot_nx;
	logic [fpcs_pkg::TICK_W-1:0]     deadline;
	logic                            run_w;

	// next state for one item
	always_comb begin
		phase_nx    = phase_q;
		run_nx      = run_q;
		next_mem_nx = next_mem_q;
		kick_nx     = kick_q;
		stamp_nx    = stamp_q;
		power_nx    = power_q;
		mem_pin_nx  = mem_pin_q;
		boot_nx     = boot_q;
		run_w       = run_q;

		// watchdog: refresh stamp on a pin change, then check expiry
		if (cfg.wdt_enable && (kick_q != item.fpga_kick)) begin
			kick_nx  = item.fpga_kick;
			stamp_nx = item.now_tick;
		end
		deadline = stamp_nx + {{(fpcs_pkg::TICK_W-8){1'b0}}, cfg.wdt_timeout};
		if (cfg.wdt_enable && (deadline < item.now_tick)) begin
			run_w = 1'b0;
		end

		if (item.action == fpcs_pkg::ACT_WRITE) begin
			kick_nx  = kick_q;
			stamp_nx = stamp_q;
			run_nx   = item.request_value;
		end else begin
			case (phase_q)
				fpcs_pkg::PH_OFF: begin
					kick_nx  = kick_q;
					stamp_nx = stamp_q;
					if (run_q) begin
						power_nx = 1'b1;
						phase_nx = fpcs_pkg::PH_READY;
					end
				end
				fpcs_pkg::PH_READY: begin
					kick_nx  = kick_q;
					stamp_nx = stamp_q;
					if (!run_q) begin
						power_nx = 1'b0;
						phase_nx = fpcs_pkg::PH_OFF;
					end else if (item.rail_good) begin
						mem_pin_nx = next_mem_q;
						boot_nx    = cfg.boot_sel;
						if (cfg.wdt_enable) begin
							kick_nx  = 1'b0;
							stamp_nx = item.now_tick;
						end
						phase_nx = fpcs_pkg::PH_CONFIG;
					end
				end
				fpcs_pkg::PH_CONFIG: begin
					run_nx = run_w;
					if (!run_w) begin
						power_nx    = 1'b0;
						next_mem_nx = ~next_mem_q;
						phase_nx    = fpcs_pkg::PH_OFF;
					end else if (item.fpga_kick) begin
						phase_nx = fpcs_pkg::PH_ACTIVE;
					end
				end
				default: begin
					run_nx = run_w;
					if (!run_w) begin
						power_nx    = 1'b0;
						next_mem_nx = ~next_mem_q;
						phase_nx    = fpcs_pkg::PH_OFF;
					end else begin
						mem_pin_nx = item.fpga_mem_choice;
					end
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= fpcs_pkg::PH_OFF;
			run_q      <= 1'b0;
			next_mem_q <= 1'b0;
			kick_q     <= 1'b0;
			stamp_q    <= '0;
			power_q    <= 1'b0;
			mem_pin_q  <= 1'b0;
			boot_q     <= 2'd0;
		end else if (fire) begin
			phase_q    <= phase_nx;
			run_q      <= run_nx;
			next_mem_q <= next_mem_nx;
			kick_q     <= kick_nx;
			stamp_q    <= stamp_nx;
			power_q    <= power_nx;
			mem_pin_q  <= mem_pin_nx;
			boot_q     <= boot_nx;
		end
	end

	// result item from the updated state
	always_comb begin
		result.phase          = phase_nx;
		result.power_enable   = power_nx;
		result.mem_select_pin = mem_pin_nx;
		result.boot_pins      = boot_nx;
		result.run_request    = run_nx;
		result.bus_accessible = (phase_nx == fpcs_pkg::PH_OFF) ||
		                        (phase_nx == fpcs_pkg::PH_READY);
	end

endmodule

`default_nettype wire

// File: hw/rtl/fpga_power_config_sequencer_top.sv
`default_nettype none

// channel  signals                     width  direction
// req      req_valid/req_stall/req     37     in, one item per step or run request write
// rsp      rsp_valid/rsp_stall/rsp     8      out, one result per accepted item
// cfg      cfg_we/cfg_idx/cfg_data     2+8    in, register writes, no read-back
//
// an item enters the input register; once the pipeline advances, it updates the
// sequencer state and loads the result register; unless rsp_stall holds the result,
// the single step stage between the two registers sets the rate of one item per cycle
// arst_n clears the sequencer state and the valid flags and reloads the config reset values
// rsp_stall holds the result register; req_stall rises only when both
// registers are full and the result is stalled

module fpga_power_config_sequencer_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 req_valid,
	output logic                                req_stall,
	input  fpcs_pkg::req_item_t                 req,
	output logic                                rsp_valid,
	input  wire                                 rsp_stall,
	output fpcs_pkg::rsp_item_t                 rsp,
	input  wire                                 cfg_we,
	input  wire [fpcs_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  wire [fpcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

	fpcs_pkg::cfg_t       cfg_q;
	fpcs_pkg::req_item_t  item_s1;
	fpcs_pkg::rsp_item_t  result;
	logic                 valid_s1;
	logic                 adv;
	logic                 fire;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wdt_enable  <= fpcs_pkg::WDT_ENABLE_RST;
			cfg_q.wdt_timeout <= fpcs_pkg::WDT_TIMEOUT_RST;
			cfg_q.boot_sel    <= fpcs_pkg::BOOT_SEL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				fpcs_pkg::CFG_WDT_ENABLE:  cfg_q.wdt_enable  <= cfg_data[0];
				fpcs_pkg::CFG_WDT_TIMEOUT: cfg_q.wdt_timeout <= cfg_data[7:0];
				fpcs_pkg::CFG_BOOT_SEL:    cfg_q.boot_sel    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves when the result register is free or being taken
	assign adv  = ~rsp_valid | ~rsp_stall;
	assign fire = valid_s1 & adv;

	fpcs_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	fpcs_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp <= result;
		end
	end

endmodule

`default_nettype wire

// File: tb/fpga_power_config_sequencer_top_tb.sv
`timescale 1ns / 100ps

module fpga_power_config_sequencer_top_tb;

	localparam int SETTING_COUNT = 8;
	localparam int ITEMS_PER_SETTING = 210;

	// register settings per run segment, segment 0 keeps the reset values
	localparam logic       SET_WDT_EN[SETTING_COUNT]  = '{1'b1, 1'b1, 1'b0, 1'b1,
		1'b0, 1'b1, 1'b1, 1'b0};
	localparam logic [7:0] SET_TIMEOUT[SETTING_COUNT] = '{8'd3, 8'd255, 8'd0, 8'd0,
		8'd255, 8'd17, 8'd1, 8'd90};
	localparam logic [1:0] SET_BOOT[SETTING_COUNT]    = '{2'd0, 2'd3, 2'd1, 2'd2,
		2'd3, 2'd1, 2'd0, 2'd2};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	fpcs_pkg::req_item_t             req = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	fpcs_pkg::rsp_item_t             rsp;
	logic                            cfg_we = 1'b0;
	logic [fpcs_pkg::CFG_IDX_W-1:0]  cfg_idx = fpcs_pkg::CFG_WDT_ENABLE;
	logic [fpcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          mismatch_count = 0;
	int          items_queued = 0;
	logic [31:0] tick_now = '0;

	fpcs_pkg::req_item_t queued_requests[$];
	fpcs_pkg::rsp_item_t predicted_status[$];

	// predictor copy of the registers and the sequencer state
	fpcs_pkg::cfg_t cfg_shadow = '{wdt_enable: fpcs_pkg::WDT_ENABLE_RST,
		wdt_timeout: fpcs_pkg::WDT_TIMEOUT_RST, boot_sel: fpcs_pkg::BOOT_SEL_RST};
	logic [1:0]  seq_phase = fpcs_pkg::PH_OFF;
	logic        run_flag = 1'b0;
	logic        next_mem = 1'b0;
	logic        kick_level = 1'b0;
	logic [31:0] kick_stamp = '0;
	logic        power_pin = 1'b0;
	logic        mem_pin = 1'b0;
	logic [1:0]  boot_pin = '0;

	fpga_power_config_sequencer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog: a level change refreshes the stamp, a stale stamp drops the run request
	function automatic void check_watchdog(logic kick, logic [31:0] now);
		logic [31:0] deadline;
		if (cfg_shadow.wdt_enable) begin
			if (kick_level != kick) begin
				kick_level = kick;
				kick_stamp = now;
			end
			deadline = kick_stamp + {24'd0, cfg_shadow.wdt_timeout};
			if (deadline < now)
				run_flag = 1'b0;
		end
	endfunction

	function automatic void power_down();
		power_pin = 1'b0;
		next_mem = ~next_mem;
		seq_phase = fpcs_pkg::PH_OFF;
	endfunction

	// one item through the sequencer, returns the pin status after the update
	function automatic fpcs_pkg::rsp_item_t sequencer_step(fpcs_pkg::req_item_t it);
		fpcs_pkg::rsp_item_t st;
		if (it.action == fpcs_pkg::ACT_WRITE) begin
			run_flag = it.request_value;
		end else begin
			case (seq_phase)
				fpcs_pkg::PH_OFF: begin
					if (run_flag) begin
						power_pin = 1'b1;
						seq_phase = fpcs_pkg::PH_READY;
					end
				end
				fpcs_pkg::PH_READY: begin
					if (!run_flag) begin
						power_pin = 1'b0;
						seq_phase = fpcs_pkg::PH_OFF;
					end else if (it.rail_good) begin
						mem_pin = next_mem;
						boot_pin = cfg_shadow.boot_sel;
						if (cfg_shadow.wdt_enable) begin
							kick_level = 1'b0;
							kick_stamp = it.now_tick;
						end
						seq_phase = fpcs_pkg::PH_CONFIG;
					end
				end
				fpcs_pkg::PH_CONFIG: begin
					check_watchdog(it.fpga_kick, it.now_tick);
					if (!run_flag)
						power_down();
					else if (it.fpga_kick)
						seq_phase = fpcs_pkg::PH_ACTIVE;
				end
				default: begin
					check_watchdog(it.fpga_kick, it.now_tick);
					if (!run_flag)
						power_down();
					else
						mem_pin = it.fpga_mem_choice;
				end
			endcase
		end
		st.phase = seq_phase;
		st.power_enable = power_pin;
		st.mem_select_pin = mem_pin;
		st.boot_pins = boot_pin;
		st.run_request = run_flag;
		st.bus_accessible = (seq_phase == fpcs_pkg::PH_OFF) ||
			(seq_phase == fpcs_pkg::PH_READY);
		return st;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// request driver: a stalled item is held, otherwise the next item is offered or not
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				predicted_status.push_back(sequencer_step(req));
			if (!(req_valid && req_stall)) begin
				if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= queued_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// status monitor: compares each accepted item with the oldest prediction
	always @(posedge clk) begin
		fpcs_pkg::rsp_item_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_status.size() == 0) begin
					report_mismatch("unexpected status", {24'd0, rsp}, '0);
				end else begin
					want = predicted_status.pop_front();
					if (rsp.phase !== want.phase)
						report_mismatch("phase", 32'(rsp.phase), 32'(want.phase));
					if (rsp.power_enable !== want.power_enable)
						report_mismatch("power_enable", 32'(rsp.power_enable),
							32'(want.power_enable));
					if (rsp.mem_select_pin !== want.mem_select_pin)
						report_mismatch("mem_select_pin", 32'(rsp.mem_select_pin),
							32'(want.mem_select_pin));
					if (rsp.boot_pins !== want.boot_pins)
						report_mismatch("boot_pins", 32'(rsp.boot_pins),
							32'(want.boot_pins));
					if (rsp.run_request !== want.run_request)
						report_mismatch("run_request", 32'(rsp.run_request),
							32'(want.run_request));
					if (rsp.bus_accessible !== want.bus_accessible)
						report_mismatch("bus_accessible", 32'(rsp.bus_accessible),
							32'(want.bus_accessible));
				end
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic rbit();
		return 1'($urandom_range(1));
	endfunction

	task automatic queue_item(logic act, logic rq, logic rail, logic kick, logic fmem,
		logic [31:0] now);
		fpcs_pkg::req_item_t it;
		it.action = act;
		it.request_value = rq;
		it.rail_good = rail;
		it.fpga_kick = kick;
		it.fpga_mem_choice = fmem;
		it.now_tick = now;
		queued_requests.push_back(it);
		items_queued++;
	endtask

	// tick mostly creeps forward, sometimes jumps or lands next to the wrap point
	function automatic logic [31:0] next_tick();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			tick_now = tick_now + $urandom_range(2);
		else if (pick < 90)
			tick_now = tick_now + $urandom_range(3, 20);
		else if (pick < 96)
			tick_now = tick_now + $urandom_range(300);
		else if (pick < 98)
			tick_now = $urandom;
		else
			tick_now = 32'hFFFF_FFFF - $urandom_range(8);
		return tick_now;
	endfunction

	// full power-up, configuration and supervised run, with random content
	task automatic queue_power_cycle();
		logic kick;
		kick = 1'b0;
		queue_item(fpcs_pkg::ACT_WRITE, 1'b1, rbit(), rbit(), rbit(), next_tick());
		queue_item(fpcs_pkg::ACT_STEP, rbit(), 1'b0, rbit(), rbit(), next_tick());
		repeat ($urandom_range(2))
			queue_item(fpcs_pkg::ACT_STEP, rbit(), 1'b0, rbit(), rbit(), next_tick());
		queue_item(fpcs_pkg::ACT_STEP, rbit(), 1'b1, 1'b0, rbit(), next_tick());
		repeat ($urandom_range(3))
			queue_item(fpcs_pkg::ACT_STEP, rbit(), rbit(), 1'b0, rbit(), next_tick());
		if ($urandom_range(9) != 0) begin
			kick = 1'b1;
			queue_item(fpcs_pkg::ACT_STEP, rbit(), rbit(), 1'b1, rbit(), next_tick());
		end
		repeat ($urandom_range(3, 14)) begin
			if ($urandom_range(2) != 0)
				kick = ~kick;
			queue_item(fpcs_pkg::ACT_STEP, rbit(), rbit(), kick, rbit(), next_tick());
		end
		case ($urandom_range(3))
			0: queue_item(fpcs_pkg::ACT_WRITE, 1'b0, rbit(), rbit(), rbit(), next_tick());
			1: begin
				queue_item(fpcs_pkg::ACT_WRITE, 1'b0, rbit(), rbit(), rbit(), next_tick());
				queue_item(fpcs_pkg::ACT_STEP, rbit(), rbit(), rbit(), rbit(), next_tick());
			end
			default: ;
		endcase
	endtask

	// hand-picked items at the reset register values
	task automatic queue_directed();
		// step while off without a run request, all other bits high
		queue_item(fpcs_pkg::ACT_STEP, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		queue_item(fpcs_pkg::ACT_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0);
		queue_item(fpcs_pkg::ACT_WRITE, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b0, 1'b0, 32'd10);
		// run request dropped while ready
		queue_item(fpcs_pkg::ACT_WRITE, 1'b0, 1'b1, 1'b1, 1'b1, 32'd11);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b1, 1'b0, 1'b0, 32'd12);
		queue_item(fpcs_pkg::ACT_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, 32'd13);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b0, 1'b0, 32'd14);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b1, 1'b1, 32'd15);
		// rail up: configuration starts and stamps the tick
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b1, 1'b0, 1'b0, 32'd100);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b0, 1'b1, 32'd101);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b1, 1'b0, 32'd102);
		// active: memory select follows the fpga
		queue_item(fpcs_pkg::ACT_STEP, 1'b1, 1'b0, 1'b1, 1'b1, 32'd103);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b1, 1'b0, 1'b0, 32'd104);
		// watchdog timeout while active
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b0, 1'b1, 32'd108);
		// restart with the flipped memory, stamp sum wraps past zero
		queue_item(fpcs_pkg::ACT_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, 32'd109);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b1, 1'b0, 1'b0, 32'd110);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFE);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
		// run request cleared by the user while configuring
		queue_item(fpcs_pkg::ACT_WRITE, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5);
		queue_item(fpcs_pkg::ACT_WRITE, 1'b0, 1'b0, 1'b0, 1'b0, 32'd6);
		queue_item(fpcs_pkg::ACT_STEP, 1'b0, 1'b0, 1'b0, 1'b0, 32'd7);
		tick_now = 32'd200;
	endtask

	task automatic wait_drained();
		while (queued_requests.size() != 0 || req_valid || predicted_status.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [fpcs_pkg::CFG_IDX_W-1:0] idx,
		logic [fpcs_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			fpcs_pkg::CFG_WDT_ENABLE:  cfg_shadow.wdt_enable = value[0];
			fpcs_pkg::CFG_WDT_TIMEOUT: cfg_shadow.wdt_timeout = value;
			fpcs_pkg::CFG_BOOT_SEL:    cfg_shadow.boot_sel = value[1:0];
			default: ;
		endcase
	endtask

	// stimulus: reset, directed items, then one random segment per register setting
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		for (int s = 0; s < SETTING_COUNT; s++) begin
			if (s > 0) begin
				wait_drained();
				write_reg(fpcs_pkg::CFG_WDT_ENABLE, {7'd0, SET_WDT_EN[s]});
				write_reg(fpcs_pkg::CFG_WDT_TIMEOUT, SET_TIMEOUT[s]);
				write_reg(fpcs_pkg::CFG_BOOT_SEL, {6'd0, SET_BOOT[s]});
			end
			case (s % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 53;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 53;
				end
				default: begin
					send_idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			items_queued = 0;
			while (items_queued < ITEMS_PER_SETTING) begin
				if ($urandom_range(9) < 8) begin
					queue_power_cycle();
				end else begin
					repeat ($urandom_range(1, 4))
						queue_item(rbit(), rbit(), rbit(), rbit(), rbit(), $urandom);
				end
			end
		end
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
